// ----- rtl/lahs_pkg.sv -----
// ---------------------------------------------------------------------------
// lahs_pkg
// Shared constants for the label area histogram and selection block.
// ---------------------------------------------------------------------------
package lahs_pkg;

    // Default sizing
    localparam int NUM_LABELS_DEF  = 256;
    localparam int COUNT_WIDTH_DEF = 25;

    // Fixed field widths
    localparam int LABEL_W     = 8;
    localparam int AREA_W      = 25;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    // Saturation limit of the reported area
    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    // Start value of the running minimum
    localparam int                     MIN_START_W = 27;
    localparam logic [MIN_START_W-1:0] MIN_START   = 27'd99999999;

    // Register reset values
    localparam logic [LABEL_W-1:0] MIN_LABEL_RST = 8'd100;
    localparam logic [LABEL_W-1:0] MAX_LABEL_RST = 8'd250;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LABEL = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LABEL = 1'b1;

    // Input operations
    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_MASK  = 1'b1;

    // Result kinds
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

endpackage

// ----- rtl/label_area_histogram_select.sv -----
// ---------------------------------------------------------------------------
// label_area_histogram_select
// Area histogram of label pixels in a synchronous counter memory, with a
// per-frame scan that selects the largest and smallest label in a range,
// and a mask pass that keeps only background and the largest label.
// ---------------------------------------------------------------------------
// Throughput: one item per cycle while in_stall is low; count items run
//   through a read-modify-write stage, forwarding the previous cycle's write.
// Masked pixels: an accepted pixel passes the stage register, then the output register.
// Last pixel: input stalls while the scan reads the counter memory, one label
//   per cycle; the summary then follows through the area and emit states.
// Reset: per-entry valid flags clear at once, so counters read as zero with
//   no clearing pass; a first pixel clears them the same way.
// ---------------------------------------------------------------------------
module label_area_histogram_select
    import lahs_pkg::*;
#(
    parameter int NUM_LABELS  = NUM_LABELS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input items
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   operation,
    input  logic                   first_pixel,
    input  logic                   last_pixel,
    input  logic [LABEL_W-1:0]     pixel_label,
    // result items
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   result_kind,
    output logic [LABEL_W-1:0]     pixel_out,
    output logic [LABEL_W-1:0]     largest_label,
    output logic [LABEL_W-1:0]     smallest_label,
    output logic [AREA_W-1:0]      largest_area
);

    localparam int CW = COUNT_WIDTH;
    localparam int AW = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
    localparam int MW = (CW > MIN_START_W) ? CW : MIN_START_W;
    localparam int SW = (CW > AREA_W) ? CW : AREA_W;

    localparam logic [CW-1:0]      CNT_MAX      = '1;
    localparam logic [LABEL_W:0]   NUM_LABELS_X = (LABEL_W+1)'(NUM_LABELS);
    localparam logic [LABEL_W-1:0] LAST_LABEL   = LABEL_W'(NUM_LABELS - 1);

    // States
    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_AREA = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    // Counter memory
    logic [CW-1:0] mem [NUM_LABELS];

    // Control state
    logic [1:0]            state_reg, state_next;
    logic [LABEL_W-1:0]    min_label_reg, min_label_next;
    logic [LABEL_W-1:0]    max_label_reg, max_label_next;
    logic [NUM_LABELS-1:0] valid_reg, valid_next;
    logic                  s2_valid_reg, s2_valid_next;
    logic                  fwd_valid_reg, fwd_valid_next;
    logic                  scan_on_reg, scan_on_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic [LABEL_W-1:0]    largest_index_reg, largest_index_next;
    logic [LABEL_W-1:0]    smallest_index_reg, smallest_index_next;

    // Payload state
    logic                  s2_op_reg, s2_op_next;
    logic                  s2_first_reg, s2_first_next;
    logic                  s2_last_reg, s2_last_next;
    logic [LABEL_W-1:0]    s2_label_reg, s2_label_next;
    logic [AW-1:0]         rd_addr_reg;
    logic [CW-1:0]         rd_data_reg;
    logic [AW-1:0]         fwd_addr_reg, fwd_addr_next;
    logic [CW-1:0]         fwd_data_reg, fwd_data_next;
    logic [LABEL_W-1:0]    scan_n_reg, scan_n_next;
    logic [LABEL_W-1:0]    cmp_label_reg, cmp_label_next;
    logic [CW-1:0]         best_max_reg, best_max_next;
    logic [MW-1:0]         best_min_reg, best_min_next;
    logic                  area_ok_reg, area_ok_next;
    logic                  kind_reg, kind_next;
    logic [LABEL_W-1:0]    pix_reg, pix_next;
    logic [LABEL_W-1:0]    lg_reg, lg_next;
    logic [LABEL_W-1:0]    sm_reg, sm_next;
    logic [AREA_W-1:0]     area_reg, area_next;

    // Combinational helpers
    logic                  out_free;
    logic                  in_accept;
    logic                  s2_count;
    logic                  s2_done;
    logic                  s2_in_range;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [CW-1:0]         wr_data;
    logic [CW-1:0]         rd_value;
    logic [CW-1:0]         old_count;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr_sel;
    logic                  range_nonempty;
    logic [LABEL_W-1:0]    scan_end;
    logic [SW-1:0]         area_ext;
    logic [CW-1:0]         area_val;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s2_count  = (s2_op_reg == OP_COUNT);
    assign s2_done   = s2_valid_reg && (s2_count || out_free);

    // Hold input while not streaming, while the stage is blocked, or behind a last pixel
    assign in_stall  = (state_reg != ST_RUN)
                    || (s2_valid_reg && !s2_done)
                    || (s2_valid_reg && s2_count && s2_last_reg);
    assign in_accept = in_valid && !in_stall;

    // Read data as the counter value: unwritten entries read as zero
    assign rd_value = valid_reg[rd_addr_reg] ? rd_data_reg : '0;

    // Read-modify-write of the counter held in the stage
    assign s2_in_range = ({1'b0, s2_label_reg} < NUM_LABELS_X);
    assign wr_addr     = s2_label_reg[AW-1:0];
    assign wr_en       = (state_reg == ST_RUN) && s2_valid_reg && s2_count && s2_in_range;

    always_comb
    begin
        if (s2_first_reg)
            old_count = '0;
        else if (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg))
            old_count = fwd_data_reg;
        else
            old_count = rd_value;
    end

    assign wr_data = (old_count < CNT_MAX) ? (old_count + CW'(1)) : old_count;

    // Scan bounds
    assign range_nonempty = (min_label_reg <= max_label_reg)
                         && ({1'b0, min_label_reg} < NUM_LABELS_X);
    assign scan_end = (max_label_reg > LAST_LABEL) ? LAST_LABEL : max_label_reg;

    // Memory read port selection
    always_comb
    begin
        rd_en       = 1'b0;
        rd_addr_sel = pixel_label[AW-1:0];
        unique case (state_reg)
            ST_RUN:
            begin
                rd_en       = in_accept;
                rd_addr_sel = pixel_label[AW-1:0];
            end
            ST_SCAN:
            begin
                rd_en       = scan_on_reg;
                rd_addr_sel = scan_n_reg[AW-1:0];
            end
            ST_AREA:
            begin
                rd_en       = 1'b1;
                rd_addr_sel = largest_index_reg[AW-1:0];
            end
            default:
            begin
                rd_en       = 1'b0;
                rd_addr_sel = largest_index_reg[AW-1:0];
            end
        endcase
    end

    // Reported area, saturated to the output field
    assign area_val = area_ok_reg ? rd_value : '0;
    assign area_ext = SW'(area_val);

    // Next-state logic
    always_comb
    begin
        state_next          = state_reg;
        min_label_next      = min_label_reg;
        max_label_next      = max_label_reg;
        valid_next          = valid_reg;
        s2_valid_next       = s2_valid_reg;
        fwd_valid_next      = wr_en;
        scan_on_next        = scan_on_reg;
        cmp_valid_next      = 1'b0;
        out_valid_next      = out_valid_reg && out_stall;
        largest_index_next  = largest_index_reg;
        smallest_index_next = smallest_index_reg;

        s2_op_next     = s2_op_reg;
        s2_first_next  = s2_first_reg;
        s2_last_next   = s2_last_reg;
        s2_label_next  = s2_label_reg;
        fwd_addr_next  = wr_addr;
        fwd_data_next  = wr_data;
        scan_n_next    = scan_n_reg;
        cmp_label_next = scan_n_reg;
        best_max_next  = best_max_reg;
        best_min_next  = best_min_reg;
        area_ok_next   = area_ok_reg;
        kind_next      = kind_reg;
        pix_next       = pix_reg;
        lg_next        = lg_reg;
        sm_next        = sm_reg;
        area_next      = area_reg;

        // configuration writes
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MIN_LABEL: min_label_next = cfg_data;
                CFG_MAX_LABEL: max_label_next = cfg_data;
                default:       ;
            endcase
        end

        unique case (state_reg)
            ST_RUN:
            begin
                // stage leaves
                if (s2_done)
                    s2_valid_next = 1'b0;

                // first pixel clears all counters
                if (s2_valid_reg && s2_count && s2_first_reg)
                    valid_next = '0;
                if (wr_en)
                    valid_next[wr_addr] = 1'b1;

                // masked pixel into the output register
                if (s2_valid_reg && !s2_count && out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_PIXEL;
                    if ((s2_label_reg != '0) && (s2_label_reg != largest_index_reg))
                        pix_next = '0;
                    else
                        pix_next = s2_label_reg;
                    lg_next   = '0;
                    sm_next   = '0;
                    area_next = '0;
                end

                // last pixel starts the scan
                if (s2_valid_reg && s2_count && s2_last_reg)
                begin
                    state_next    = ST_SCAN;
                    scan_n_next   = min_label_reg;
                    scan_on_next  = range_nonempty;
                    best_max_next = '0;
                    best_min_next = MW'(MIN_START);
                end

                // capture new item
                if (in_accept)
                begin
                    s2_valid_next = 1'b1;
                    s2_op_next    = operation;
                    s2_first_next = first_pixel;
                    s2_last_next  = last_pixel;
                    s2_label_next = pixel_label;
                end
            end

            ST_SCAN:
            begin
                // issue reads over the range
                if (scan_on_reg)
                begin
                    cmp_valid_next = 1'b1;
                    if (scan_n_reg == scan_end)
                        scan_on_next = 1'b0;
                    else
                        scan_n_next = scan_n_reg + LABEL_W'(1);
                end

                // strict compares: lowest label wins a tie
                if (cmp_valid_reg)
                begin
                    if (best_max_reg < rd_value)
                    begin
                        best_max_next      = rd_value;
                        largest_index_next = cmp_label_reg;
                    end
                    if (best_min_reg > MW'(rd_value))
                    begin
                        best_min_next       = MW'(rd_value);
                        smallest_index_next = cmp_label_reg;
                    end
                end

                if (!scan_on_reg && !cmp_valid_reg)
                    state_next = ST_AREA;
            end

            ST_AREA:
            begin
                area_ok_next = ({1'b0, largest_index_reg} < NUM_LABELS_X);
                state_next   = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_SUMMARY;
                    pix_next       = '0;
                    lg_next        = largest_index_reg;
                    sm_next        = smallest_index_reg;
                    area_next      = (area_ext > SW'(AREA_MAX)) ? AREA_MAX
                                                                 : AREA_W'(area_ext);
                    state_next     = ST_RUN;
                end
            end

            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_RUN;
            min_label_reg      <= MIN_LABEL_RST;
            max_label_reg      <= MAX_LABEL_RST;
            valid_reg          <= '0;
            s2_valid_reg       <= 1'b0;
            fwd_valid_reg      <= 1'b0;
            scan_on_reg        <= 1'b0;
            cmp_valid_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
            largest_index_reg  <= '0;
            smallest_index_reg <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            min_label_reg      <= min_label_next;
            max_label_reg      <= max_label_next;
            valid_reg          <= valid_next;
            s2_valid_reg       <= s2_valid_next;
            fwd_valid_reg      <= fwd_valid_next;
            scan_on_reg        <= scan_on_next;
            cmp_valid_reg      <= cmp_valid_next;
            out_valid_reg      <= out_valid_next;
            largest_index_reg  <= largest_index_next;
            smallest_index_reg <= smallest_index_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s2_op_reg     <= s2_op_next;
        s2_first_reg  <= s2_first_next;
        s2_last_reg   <= s2_last_next;
        s2_label_reg  <= s2_label_next;
        fwd_addr_reg  <= fwd_addr_next;
        fwd_data_reg  <= fwd_data_next;
        scan_n_reg    <= scan_n_next;
        cmp_label_reg <= cmp_label_next;
        best_max_reg  <= best_max_next;
        best_min_reg  <= best_min_next;
        area_ok_reg   <= area_ok_next;
        kind_reg      <= kind_next;
        pix_reg       <= pix_next;
        lg_reg        <= lg_next;
        sm_reg        <= sm_next;
        area_reg      <= area_next;
    end

    // Counter memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_addr_reg <= rd_addr_sel;
            rd_data_reg <= mem[rd_addr_sel];
        end
    end

    // Outputs
    assign out_valid      = out_valid_reg;
    assign result_kind    = kind_reg;
    assign pixel_out      = pix_reg;
    assign largest_label  = lg_reg;
    assign smallest_label = sm_reg;
    assign largest_area   = area_reg;

endmodule
